// ----- hdl/cave_automaton_generation_step_assert.svh -----
// Assertion macros for the cave automaton generation step.
// Used by modules with ports named clock and reset.
`ifndef CAVE_AUTOMATON_GENERATION_STEP_ASSERT_SVH
`define CAVE_AUTOMATON_GENERATION_STEP_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define CAGS_ASSERT_NOW(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// Condition must hold in the cycle after the trigger.
`define CAGS_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ----- hdl/cags_pkg.sv -----
// Shared types, constants and helpers for the cave automaton generation step.
// No dependencies.
package cags_pkg;

   localparam int MAX_COLS   = 64;
   localparam int LANE_CELLS = 8;
   localparam int LANE_COUNT = MAX_COLS / LANE_CELLS;
   localparam int COL_W      = 7;
   localparam int LIMIT_W    = 4;
   localparam int CNT_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIRTH_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEATH_LIMIT = 2'd2;

   localparam logic [COL_W-1:0]   COL_COUNT_RESET   = COL_W'(MAX_COLS);
   localparam logic [LIMIT_W-1:0] BIRTH_LIMIT_RESET = 4'd3;
   localparam logic [LIMIT_W-1:0] DEATH_LIMIT_RESET = 4'd3;

   typedef logic [MAX_COLS-1:0]     row_type;
   typedef logic [LANE_CELLS+1:0]   lane_win_type;
   typedef logic [LANE_CELLS-1:0]   lane_cells_type;

   typedef struct packed {
      logic [COL_W-1:0]   col_count;
      logic [LIMIT_W-1:0] birth_limit;
      logic [LIMIT_W-1:0] death_limit;
   } cfg_type;

   typedef struct packed {
      row_type up;
      row_type mid;
      row_type down;
      logic    frame_end;
   } job_type;

   // Bit k is set when column k lies inside the grid. Counts above the row
   // width simply select every column.
   function automatic row_type width_mask(input logic [COL_W-1:0] n);
      row_type m;
      for (int k = 0; k < MAX_COLS; k++) begin
         m[k] = (COL_W'(k) < n);
      end
      return m;
   endfunction

endpackage

// ----- hdl/cags_lane.sv -----
// One lane: next generation of a group of adjacent cells from 3x3 windows.
// Depends on cags_pkg.
module cags_lane
   import cags_pkg::*;
(
   input  lane_win_type       up_win,
   input  lane_win_type       mid_win,
   input  lane_win_type       down_win,
   input  lane_cells_type     active,
   input  logic [LIMIT_W-1:0] birth_limit,
   input  logic [LIMIT_W-1:0] death_limit,
   output lane_cells_type     cells
);

   always_comb begin
      logic [CNT_W-1:0] cnt;
      cnt = '0;
      for (int i = 0; i < LANE_CELLS; i++) begin
         // Window bit i+1 is the cell itself; i and i+2 are its neighbors.
         cnt = CNT_W'(up_win[i])   + CNT_W'(up_win[i+1])   + CNT_W'(up_win[i+2])
             + CNT_W'(mid_win[i])  + CNT_W'(mid_win[i+1])  + CNT_W'(mid_win[i+2])
             + CNT_W'(down_win[i]) + CNT_W'(down_win[i+1]) + CNT_W'(down_win[i+2]);
         if (mid_win[i+1]) begin
            cells[i] = active[i] & (cnt >= death_limit);
         end else begin
            cells[i] = active[i] & (cnt > birth_limit);
         end
      end
   end

endmodule

// ----- hdl/cags_gen.sv -----
// Row generator: pads three rows with the live border, runs the lanes side by
// side and merges their cell groups into one row. Depends on cags_pkg, cags_lane.
module cags_gen
   import cags_pkg::*;
(
   input  job_type cfg_job,
   input  cfg_type cfg,
   output row_type new_row
);

   row_type                   mask;
   logic [MAX_COLS+1:0]       up_ext;
   logic [MAX_COLS+1:0]       mid_ext;
   logic [MAX_COLS+1:0]       down_ext;
   lane_cells_type            lane_out [LANE_COUNT];

   // Columns outside the active width, and the border columns beyond both edges, read alive.
   assign mask     = width_mask(cfg.col_count);
   assign up_ext   = {1'b1, cfg_job.up   | ~mask, 1'b1};
   assign mid_ext  = {1'b1, cfg_job.mid  | ~mask, 1'b1};
   assign down_ext = {1'b1, cfg_job.down | ~mask, 1'b1};

   for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
      cags_lane u_lane (
         .up_win      (up_ext[g*LANE_CELLS +: LANE_CELLS+2]),
         .mid_win     (mid_ext[g*LANE_CELLS +: LANE_CELLS+2]),
         .down_win    (down_ext[g*LANE_CELLS +: LANE_CELLS+2]),
         .active      (mask[g*LANE_CELLS +: LANE_CELLS]),
         .birth_limit (cfg.birth_limit),
         .death_limit (cfg.death_limit),
         .cells       (lane_out[g])
      );
      assign new_row[g*LANE_CELLS +: LANE_CELLS] = lane_out[g];
   end

endmodule

// ----- hdl/cave_automaton_generation_step.sv -----
// Top level of the cave automaton generation step: row window, job and output
// registers. Depends on cags_pkg, cags_gen and the assertion macro header.
//
// Usage: the grid streams in on the req_ channel one row per transfer, top row
// first, with req_last_row set on the final row. Each new-generation row leaves
// on the rsp_ channel once the row below it has arrived; the final row of the
// grid releases two results, the row above it and then itself, the second one
// carrying rsp_frame_end. A one-row grid gives a single result with frame_end.
// A released result moves through the job register and then the output register.
// Throughput: one row per cycle while rsp_stall is low; after the last row of a
// grid of two or more rows, req_stall holds off input until the follow-up job moves.
// The cells of all 64 columns are computed combinationally by eight lanes of eight
// cells each, between the job register and the output register.
// When the receiver stalls, the output register holds its result and the job
// register can still take one more row before req_stall rises.
// Reset (synchronous) empties the pipeline, clears the row window to the start
// of a grid and loads the default register values: 64 columns, limits of 3.
// Registers must be written through csr_write/csr_index/csr_data only while the
// block is idle (not enforced by the block); they apply from the next row.
`include "cave_automaton_generation_step_assert.svh"

module cave_automaton_generation_step
   import cags_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  row_type               req_row_cells,
   input  logic                  req_last_row,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output row_type               rsp_new_row,
   output logic                  rsp_frame_end
);

   localparam row_type BORDER = '1;

   cfg_type cfg_ff, cfg_in;

   // Row window: the row above the pending middle row, and the middle row.
   row_type row_above_ff, row_above_in;
   row_type row_middle_ff, row_middle_in;
   logic    middle_valid_ff, middle_valid_in;

   // Job register feeding the lanes, plus the follow-up job of a final row.
   job_type job_ff, job_in;
   logic    job_valid_ff, job_valid_in;
   logic    fu_valid_ff, fu_valid_in;
   row_type fu_up_ff, fu_up_in;
   row_type fu_mid_ff, fu_mid_in;

   logic    out_valid_ff, out_valid_in;
   row_type out_row_ff, out_row_in;
   logic    out_fend_ff, out_fend_in;

   row_type gen_row;
   logic    out_load;
   logic    job_adv;
   logic    job_free;
   logic    req_take;

   cags_gen u_gen (
      .cfg_job (job_ff),
      .cfg     (cfg_ff),
      .new_row (gen_row)
   );

   // The output register takes a new result whenever it is empty or its
   // result is transferred in this cycle.
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign job_adv   = job_valid_ff && out_load;
   assign job_free  = !job_valid_ff || job_adv;
   assign req_stall = fu_valid_ff || !job_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_COL_COUNT:   cfg_in.col_count   = csr_data[COL_W-1:0];
            CSR_BIRTH_LIMIT: cfg_in.birth_limit = csr_data[LIMIT_W-1:0];
            CSR_DEATH_LIMIT: cfg_in.death_limit = csr_data[LIMIT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      row_above_in    = row_above_ff;
      row_middle_in   = row_middle_ff;
      middle_valid_in = middle_valid_ff;
      job_in          = job_ff;
      job_valid_in    = job_valid_ff && !job_adv;
      fu_valid_in     = fu_valid_ff;
      fu_up_in        = fu_up_ff;
      fu_mid_in       = fu_mid_ff;

      if (fu_valid_ff && job_free) begin
         // Second result of a final row: that row with the border below it.
         job_in.up        = fu_up_ff;
         job_in.mid       = fu_mid_ff;
         job_in.down      = BORDER;
         job_in.frame_end = 1'b1;
         job_valid_in     = 1'b1;
         fu_valid_in      = 1'b0;
      end else if (req_take) begin
         if (!middle_valid_ff) begin
            if (req_last_row) begin
               // A one-row grid sees the live border above and below.
               job_in.up        = BORDER;
               job_in.mid       = req_row_cells;
               job_in.down      = BORDER;
               job_in.frame_end = 1'b1;
               job_valid_in     = 1'b1;
               row_above_in     = BORDER;
               row_middle_in    = '0;
               middle_valid_in  = 1'b0;
            end else begin
               row_middle_in   = req_row_cells;
               middle_valid_in = 1'b1;
            end
         end else begin
            job_in.up        = row_above_ff;
            job_in.mid       = row_middle_ff;
            job_in.down      = req_row_cells;
            job_in.frame_end = 1'b0;
            job_valid_in     = 1'b1;
            if (req_last_row) begin
               fu_valid_in     = 1'b1;
               fu_up_in        = row_middle_ff;
               fu_mid_in       = req_row_cells;
               row_above_in    = BORDER;
               row_middle_in   = '0;
               middle_valid_in = 1'b0;
            end else begin
               row_above_in  = row_middle_ff;
               row_middle_in = req_row_cells;
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_row_in   = out_row_ff;
      out_fend_in  = out_fend_ff;
      if (out_load) begin
         out_valid_in = job_valid_ff;
         out_row_in   = gen_row;
         out_fend_in  = job_ff.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.col_count   <= COL_COUNT_RESET;
         cfg_ff.birth_limit <= BIRTH_LIMIT_RESET;
         cfg_ff.death_limit <= DEATH_LIMIT_RESET;
         row_above_ff       <= BORDER;
         row_middle_ff      <= '0;
         middle_valid_ff    <= 1'b0;
         job_valid_ff       <= 1'b0;
         fu_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
      end else begin
         cfg_ff          <= cfg_in;
         row_above_ff    <= row_above_in;
         row_middle_ff   <= row_middle_in;
         middle_valid_ff <= middle_valid_in;
         job_valid_ff    <= job_valid_in;
         fu_valid_ff     <= fu_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      fu_up_ff    <= fu_up_in;
      fu_mid_ff   <= fu_mid_in;
      out_row_ff  <= out_row_in;
      out_fend_ff <= out_fend_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_new_row   = out_row_ff;
   assign rsp_frame_end = out_fend_ff;

   // A pending follow-up job always sits behind a job that is still held.
   `CAGS_ASSERT_NOW(a_fu_behind_job, fu_valid_ff, job_valid_ff,
      "follow-up job pending with an empty job register")
   // The row window is back at the start of a grid while the follow-up waits.
   `CAGS_ASSERT_NOW(a_fu_window_clear, fu_valid_ff, !middle_valid_ff,
      "row window not cleared behind a final row")
   // A final row after a stored middle row schedules its second result.
   `CAGS_ASSERT_NEXT(a_last_sets_fu, req_take && req_last_row && middle_valid_ff,
      fu_valid_ff && job_valid_ff, "final row did not schedule two results")
   // Any row that is not final leaves a middle row stored.
   `CAGS_ASSERT_NEXT(a_row_stored, req_take && !req_last_row, middle_valid_ff,
      "accepted row not kept as middle row")

endmodule
